@@ design/qcc_pkg.sv @@
// ----------------------------------------------------------------------------
// qcc_pkg: shared types and helpers for the quadrature clamped counter
// Command codes, register indexes, configuration and result structs, and the
// clamp function used by the count update.
// ----------------------------------------------------------------------------
package qcc_pkg;

  // Default count multiplier for load and step commands
  localparam int SCALE_DEFAULT = 2;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int LOAD_W  = 16;
  localparam int COUNT_W = 32;
  localparam int STEP_W  = 16;
  localparam int INDEX_W = 3;

  // Working width for count arithmetic: count plus a scaled step never overflows
  localparam int CALC_W  = COUNT_W + 2;

  // Command codes carried in the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_UP     = 3'd2,
    CMD_DOWN   = 3'd3,
    CMD_TAKE   = 3'd4
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_CLAMP_LO    = 3'd0,
    REG_CLAMP_HI    = 3'd1,
    REG_STEP_SIZE   = 3'd2,
    REG_REVERSE_DIR = 3'd3,
    REG_LOCK        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COUNT_W-1:0] clamp_lo;
    logic signed [COUNT_W-1:0] clamp_hi;
    logic        [STEP_W-1:0]  step_size;
    logic                      reverse_direction;
    logic                      lock;
  } cfg_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count_value;
    logic                      changed;
  } result_t;

  // Clamp: below min gives min, else above max gives max
  function automatic logic signed [COUNT_W-1:0] clamp_count(
    input logic signed [CALC_W-1:0]  x,
    input logic signed [COUNT_W-1:0] lo,
    input logic signed [COUNT_W-1:0] hi
  );
    logic signed [CALC_W-1:0]  lo_x;
    logic signed [CALC_W-1:0]  hi_x;
    logic signed [COUNT_W-1:0] res;
    lo_x = CALC_W'(lo);
    hi_x = CALC_W'(hi);
    if (x < lo_x) begin
      res = lo;
    end else if (x > hi_x) begin
      res = hi;
    end else begin
      res = x[COUNT_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ design/qcc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// qcc_cfg_regs: configuration register file
// Holds the clamp limits, step size, direction and lock settings written
// through the plain write port.
// ----------------------------------------------------------------------------
module qcc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qcc_pkg::INDEX_W-1:0] cfg_index,
  input  logic [qcc_pkg::COUNT_W-1:0] cfg_data,
  output qcc_pkg::cfg_t               cfg
);
  import qcc_pkg::*;

  // Write the addressed register; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLAMP_LO:    cfg.clamp_lo          <= $signed(cfg_data);
        REG_CLAMP_HI:    cfg.clamp_hi          <= $signed(cfg_data);
        REG_STEP_SIZE:   cfg.step_size         <= cfg_data[STEP_W-1:0];
        REG_REVERSE_DIR: cfg.reverse_direction <= cfg_data[0];
        REG_LOCK:        cfg.lock              <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/qcc_core.sv @@
// ----------------------------------------------------------------------------
// qcc_core: count state and single-pass update
// Decodes one command, updates the count, pin history and changed flag on
// the accepting edge, and presents the result for the output register.
// ----------------------------------------------------------------------------
module qcc_core #(
  parameter int SCALE = qcc_pkg::SCALE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [qcc_pkg::CMD_W-1:0]        command,
  input  logic                             pin_a,
  input  logic                             pin_b,
  input  logic signed [qcc_pkg::LOAD_W-1:0] load_value,
  input  qcc_pkg::cfg_t                    cfg,
  output qcc_pkg::result_t                 result
);
  import qcc_pkg::*;

  localparam int SCALE_W  = $clog2(SCALE + 1);
  localparam int SSTEP_W  = STEP_W + SCALE_W;
  localparam int SLOAD_W  = LOAD_W + SCALE_W + 1;

  // State registers
  logic signed [COUNT_W-1:0] count_reg;
  logic signed [COUNT_W-1:0] count_seen;
  logic                      changed_flag;
  logic                      last_a;
  logic                      last_b;
  logic                      last_phase;

  logic signed [COUNT_W-1:0] count_reg_next;
  logic signed [COUNT_W-1:0] count_seen_next;
  logic                      changed_flag_next;
  logic                      last_a_next;
  logic                      last_b_next;
  logic                      last_phase_next;
  logic                      flag_out;

  logic signed [CALC_W-1:0]  count_ext;
  logic signed [CALC_W-1:0]  step_mag;
  logic signed [CALC_W-1:0]  pin_move;
  logic                      phase;
  logic signed [COUNT_W-1:0] first_move;
  logic signed [COUNT_W-1:0] second_move;
  logic        [SSTEP_W-1:0] scaled_step;
  logic signed [SLOAD_W-1:0] scaled_load;

  // Operands shared by the command arms
  assign count_ext   = CALC_W'(count_reg);
  assign step_mag    = $signed(CALC_W'(cfg.step_size));
  assign phase       = (pin_a == pin_b);
  assign pin_move    = (phase ^ cfg.reverse_direction) ? step_mag : -step_mag;
  assign first_move  = clamp_count(count_ext + pin_move, cfg.clamp_lo, cfg.clamp_hi);
  assign second_move = clamp_count(CALC_W'(first_move) + pin_move,
                                   cfg.clamp_lo, cfg.clamp_hi);
  assign scaled_step = SSTEP_W'(cfg.step_size) * SSTEP_W'(SCALE);
  assign scaled_load = SLOAD_W'(load_value) * $signed(SLOAD_W'(SCALE));

  // Next state for one command
  always_comb begin
    count_reg_next    = count_reg;
    count_seen_next   = count_seen;
    changed_flag_next = changed_flag;
    last_a_next       = last_a;
    last_b_next       = last_b;
    last_phase_next   = last_phase;
    flag_out          = changed_flag;
    unique case (command)
      CMD_SAMPLE: begin
        if (!cfg.lock) begin
          // Move only when both channels toggled; move again on a phase flip
          if (pin_a != last_a) begin
            last_a_next = pin_a;
            if (pin_b != last_b) begin
              last_b_next     = pin_b;
              last_phase_next = phase;
              count_reg_next  = (phase != last_phase) ? second_move : first_move;
            end
          end
          if (count_reg_next != count_seen) begin
            count_seen_next   = count_reg_next;
            changed_flag_next = 1'b1;
          end
          flag_out = changed_flag_next;
        end
      end
      CMD_LOAD: begin
        count_reg_next = clamp_count(CALC_W'(scaled_load), cfg.clamp_lo, cfg.clamp_hi);
      end
      CMD_UP: begin
        count_reg_next = clamp_count(count_ext + $signed(CALC_W'(scaled_step)),
                                     cfg.clamp_lo, cfg.clamp_hi);
      end
      CMD_DOWN: begin
        count_reg_next = clamp_count(count_ext - $signed(CALC_W'(scaled_step)),
                                     cfg.clamp_lo, cfg.clamp_hi);
      end
      CMD_TAKE: begin
        changed_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign result.count_value = count_reg_next;
  assign result.changed     = flag_out;

  // Commit state on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg    <= '0;
      count_seen   <= '0;
      changed_flag <= 1'b0;
      last_a       <= 1'b0;
      last_b       <= 1'b0;
      last_phase   <= 1'b0;
    end else if (accept) begin
      count_reg    <= count_reg_next;
      count_seen   <= count_seen_next;
      changed_flag <= changed_flag_next;
      last_a       <= last_a_next;
      last_b       <= last_b_next;
      last_phase   <= last_phase_next;
    end
  end

endmodule

@@ design/quadrature_clamped_counter.sv @@
// Output: a result appears on the master side in the cycle after its input
//   transaction is accepted.
// Throughput: one transaction per cycle while the master side is not stalled;
//   the count update loop finishes in the accepting cycle, so the next item may follow directly.
// Reset: synchronous rst clears count, pin history, changed flag, all
//   configuration registers and the output valid flag.
// ----------------------------------------------------------------------------
// quadrature_clamped_counter: quadrature decoder with clamped signed count
// Takes pin samples and commands, updates the clamped count in one pass and
// returns one result per input through an output register.
// ----------------------------------------------------------------------------
module quadrature_clamped_counter #(
  parameter int SCALE = qcc_pkg::SCALE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qcc_pkg::INDEX_W-1:0] cfg_index,
  input  logic [qcc_pkg::COUNT_W-1:0] cfg_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // pin_a, pin_b, load_value[15:0], zero pad
  input  logic [qcc_pkg::CMD_W-1:0]   s_axis_tuser,  // command[2:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [qcc_pkg::COUNT_W-1:0] m_axis_tdata,  // count_value[31:0]
  output logic                        m_axis_tuser   // changed
);
  import qcc_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    accept;

  // Take a new transaction whenever the output register is free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  qcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qcc_core #(
    .SCALE (SCALE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (s_axis_tuser),
    .pin_a      (s_axis_tdata[0]),
    .pin_b      (s_axis_tdata[1]),
    .load_value ($signed(s_axis_tdata[LOAD_W+1:2])),
    .cfg        (cfg),
    .result     (result)
  );

  // Output valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  // Output payload: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= result.count_value;
      m_axis_tuser <= result.changed;
    end
  end

endmodule

@@ design/qcc_checker.sv @@
// ----------------------------------------------------------------------------
// qcc_checker: port-level checks for the quadrature clamped counter
// Watches the stream handshakes on the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module qcc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [qcc_pkg::COUNT_W-1:0] m_axis_tdata,
  input logic                        m_axis_tuser
);
  import qcc_pkg::*;

  // No result is pending right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // An empty output register never stalls the input
  assert property (@(posedge clk) disable iff (rst) !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Every accepted transaction shows a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted transaction lost");

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind quadrature_clamped_counter qcc_checker u_qcc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ sim/quadrature_clamped_counter_tb.sv @@
// ----------------------------------------------------------------------------
// quadrature_clamped_counter_tb: self-checking bench for the clamped counter
// Drives pin samples and commands over the input stream with random gaps, and
// predicts each result with a local model of the decoder and clamp. It then
// compares every output transaction field by field against the oldest
// prediction. Runs several register settings, including the extreme limits,
// a lower limit above the upper one, reversed direction and locked pins.
// ----------------------------------------------------------------------------
module quadrature_clamped_counter_tb;
  import qcc_pkg::*;

  localparam int COUNT_SCALE = SCALE_DEFAULT;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    cmd_e               cmd;
    logic               pin_a;
    logic               pin_b;
    logic signed [15:0] load_value;
  } move_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [INDEX_W-1:0]    cfg_index = '0;
  logic [COUNT_W-1:0]    cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;   // pin_a, pin_b, load_value[15:0], zero pad
  logic [CMD_W-1:0]      s_axis_tuser = '0;   // command[2:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [COUNT_W-1:0]    m_axis_tdata;        // count_value[31:0]
  logic                  m_axis_tuser;        // changed

  // Register shadow
  logic signed [31:0] lim_lo = '0;
  logic signed [31:0] lim_hi = '0;
  logic [15:0]        step_amt = '0;
  logic               rev_dir = 1'b0;
  logic               pins_locked = 1'b0;

  // Decoder state shadow
  logic signed [31:0] count_now = '0;
  logic signed [31:0] count_noticed = '0;
  logic               changed_now = 1'b0;
  logic               last_pin_a = 1'b0;
  logic               last_pin_b = 1'b0;
  logic               last_phase_eq = 1'b0;

  // Pin levels the stimulus generator walks through
  logic gen_a = 1'b0;
  logic gen_b = 1'b0;

  move_t   pending_moves[$];
  result_t expected_counts[$];
  move_t   cur_move;
  logic    offering = 1'b0;
  int      tx_gap = 0;
  int      tx_burst = 0;
  int      rx_stall = 0;
  int      rx_burst = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      results_seen = 0;
  int      mismatches = 0;

  quadrature_clamped_counter #(.SCALE(COUNT_SCALE)) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp in 64 bits: below the lower limit wins first
  function automatic logic signed [31:0] limit_count(input longint x);
    if (x < longint'(lim_lo)) begin
      return lim_lo;
    end else if (x > longint'(lim_hi)) begin
      return lim_hi;
    end
    return x[31:0];
  endfunction

  // Advance the decoder shadow by one transaction and return its result
  function automatic result_t advance_counter(input move_t mv);
    longint  step;
    longint  delta;
    logic    phase_eq;
    logic    flag_before;
    result_t res;
    case (mv.cmd)
      CMD_SAMPLE: begin
        if (!pins_locked) begin
          if (mv.pin_a != last_pin_a) begin
            last_pin_a = mv.pin_a;
            if (mv.pin_b != last_pin_b) begin
              step = rev_dir ? -longint'(step_amt) : longint'(step_amt);
              phase_eq = (mv.pin_a == mv.pin_b);
              delta = phase_eq ? step : -step;
              last_pin_b = mv.pin_b;
              count_now = limit_count(longint'(count_now) + delta);
              // phase flip moves a second time
              if (phase_eq != last_phase_eq) begin
                count_now = limit_count(longint'(count_now) + delta);
              end
              last_phase_eq = phase_eq;
            end
          end
          if (count_now != count_noticed) begin
            count_noticed = count_now;
            changed_now = 1'b1;
          end
        end
      end
      CMD_LOAD: count_now = limit_count(longint'(mv.load_value) * COUNT_SCALE);
      CMD_UP:   count_now = limit_count(longint'(count_now) + longint'(step_amt) * COUNT_SCALE);
      CMD_DOWN: count_now = limit_count(longint'(count_now) - longint'(step_amt) * COUNT_SCALE);
      default: ;
    endcase
    flag_before = changed_now;
    if (mv.cmd == CMD_TAKE) begin
      changed_now = 1'b0;
    end
    res.count_value = count_now;
    res.changed = flag_before;
    return res;
  endfunction

  // Mostly short gaps, some long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic move_t make_move(input cmd_e c, input logic a, input logic b,
                                      input logic signed [15:0] v);
    move_t mv;
    mv.cmd = c;
    mv.pin_a = a;
    mv.pin_b = b;
    mv.load_value = v;
    return mv;
  endfunction

  // Both-pin toggles that move the count are the most common move, plus single
  // noise and commands
  function automatic move_t next_random_move();
    move_t       mv;
    int unsigned r;
    r = $urandom_range(0, 99);
    mv = make_move(CMD_SAMPLE, 1'($urandom), 1'($urandom), 16'($urandom));
    if (r < 40) begin
      gen_a = ~gen_a;
      gen_b = ~gen_b;
    end else if (r < 55) begin
      if ($urandom_range(0, 1)) gen_a = ~gen_a;
      else gen_b = ~gen_b;
    end else if (r < 62) begin
      gen_a = 1'($urandom);
      gen_b = 1'($urandom);
    end else if (r < 72) begin
      mv.cmd = CMD_LOAD;
      if ($urandom_range(0, 7) == 0) begin
        mv.load_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
    end else if (r < 82) begin
      mv.cmd = CMD_UP;
    end else if (r < 92) begin
      mv.cmd = CMD_DOWN;
    end else begin
      mv.cmd = CMD_TAKE;
    end
    if (mv.cmd == CMD_SAMPLE) begin
      mv.pin_a = gen_a;
      mv.pin_b = gen_b;
    end
    return mv;
  endfunction

  // Driver: present pending moves, predict each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_counts.push_back(advance_counter(cur_move));
        offering = 1'b0;
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_moves.size() > 0) begin
          cur_move = pending_moves.pop_front();
          offering = 1'b1;
          if (tx_burst > 0) begin
            tx_burst--;
            tx_gap = 0;
          end else if ($urandom_range(0, 19) == 0) begin
            tx_burst = 30;
            tx_gap = 0;
          end else begin
            tx_gap = pick_gap();
          end
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tdata  <= {6'd0, cur_move.load_value, cur_move.pin_b, cur_move.pin_a};
      s_axis_tuser  <= cur_move.cmd;
    end
  end

  // Monitor: check results, stall the receiver, hold off once for long
  always @(posedge clk) begin : rx_side
    result_t want;
    int unsigned r;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_counts.size() == 0) begin
          $error("unexpected result: count_value %0d, changed %0d",
                 $signed(m_axis_tdata), m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (m_axis_tdata !== want.count_value) begin
            $error("count_value: expected %0d, got %0d",
                   want.count_value, $signed(m_axis_tdata));
            mismatches++;
          end
          if (m_axis_tuser !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= 150 && pending_moves.size() > 20) begin
        // let the block fill and back up its input
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end else if (rx_burst > 0) begin
        rx_burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          rx_burst = 30;
        end else if (r < 25) begin
          rx_stall = pick_gap();
        end
      end
      m_axis_tready <= (hold_left == 0) && (rx_stall == 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // Block until every move went in and every result came back
  task automatic wait_idle();
    while (pending_moves.size() != 0 || offering || expected_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_CLAMP_LO:    lim_lo = value;
      REG_CLAMP_HI:    lim_hi = value;
      REG_STEP_SIZE:   step_amt = value[15:0];
      REG_REVERSE_DIR: rev_dir = value[0];
      REG_LOCK:        pins_locked = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [15:0] step, input logic rev, input logic lk);
    wait_idle();
    write_reg(REG_CLAMP_LO, lo);
    write_reg(REG_CLAMP_HI, hi);
    write_reg(REG_STEP_SIZE, {16'd0, step});
    write_reg(REG_REVERSE_DIR, {31'd0, rev});
    write_reg(REG_LOCK, {31'd0, lk});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      pending_moves.push_back(next_random_move());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: moves, phase flips, single-pin changes, load extremes, clamps
    configure(-32'sd1000, 32'sd1000, 16'd5, 1'b0, 1'b0);
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b1, 1'b1, 16'sd0));
    pending_moves.push_back(make_move(CMD_TAKE,   1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_TAKE,   1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b1, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b0, 1'b1, 16'sd0));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b0, 1'b1, 16'sd0));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b1, 1'b1, 16'sd0));
    pending_moves.push_back(make_move(CMD_LOAD,   1'b1, 1'b1, 16'sh7fff));
    pending_moves.push_back(make_move(CMD_UP,     1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_LOAD,   1'b0, 1'b1, 16'sh8000));
    pending_moves.push_back(make_move(CMD_DOWN,   1'b1, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_LOAD,   1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_UP,     1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_DOWN,   1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_LOAD,   1'b0, 1'b0, 16'sd1));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b1, 1'b1, 16'sd0));
    pending_moves.push_back(make_move(CMD_TAKE,   1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_LOAD,   1'b0, 1'b0, -16'sd1));
    pending_moves.push_back(make_move(CMD_SAMPLE, 1'b0, 1'b0, 16'sd0));
    pending_moves.push_back(make_move(CMD_TAKE,   1'b0, 1'b0, 16'sd0));
    gen_a = 1'b0;
    gen_b = 1'b0;
    queue_random(90);

    // Full range, largest step
    configure(32'sh8000_0000, 32'sh7fff_ffff, 16'hffff, 1'b0, 1'b0);
    queue_random(100);
    // Narrow window, reversed
    configure(-32'sd300, 32'sd200, 16'd7, 1'b1, 1'b0);
    queue_random(100);
    // Lower limit above upper limit
    configure(32'sd100, -32'sd100, 16'd3, 1'b0, 1'b0);
    queue_random(100);
    // Pins locked out
    configure(-32'sd5000, 32'sd5000, 16'd1, 1'b1, 1'b1);
    queue_random(100);
    // Window at the top of the range
    configure(32'sd2147483000, 32'sh7fff_ffff, 16'hffff, 1'b1, 1'b0);
    queue_random(100);
    // Window at the bottom of the range
    configure(32'sh8000_0000, -32'sd2147482000, 16'd1000, 1'b0, 1'b0);
    queue_random(100);
    // Back to the reset values
    configure(32'sd0, 32'sd0, 16'd0, 1'b0, 1'b0);
    queue_random(100);
    // Random window and step
    configure(-32'($urandom_range(0, 100000)), 32'($urandom_range(0, 100000)),
              16'($urandom), 1'($urandom), 1'b0);
    queue_random(100);

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/qcc_pkg.sv
design/qcc_cfg_regs.sv
design/qcc_core.sv
design/quadrature_clamped_counter.sv
design/qcc_checker.sv
sim/quadrature_clamped_counter_tb.sv
